@@ sv/pef_pkg.sv @@
package pef_pkg;

  // field widths fixed by the port definition
  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 16;
  localparam int SPACING_W = 12;
  localparam int POS_W     = 12;
  localparam int COUNT_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_VAL_W = 16;

  // defaults for the top level parameters
  localparam int MAX_LEN_DEF     = 4096;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KIND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd2;

  // extremum kind codes
  localparam logic KIND_PEAK   = 1'b0;
  localparam logic KIND_VALLEY = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                is_last;
  } in_beat_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] total;
    logic               done_res;
  } res_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_VAL_W-1:0] value;
  } cfg_beat_t;

  typedef struct packed {
    logic                 kind;
    logic [LEVEL_W-1:0]   level;
    logic [SPACING_W-1:0] spacing;
  } cfg_regs_t;

endpackage

@@ sv/pef_chan_if.sv @@
interface pef_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/pef_cfg.sv @@
module pef_cfg (
  input  logic          clk,
  input  logic          rst,
  pef_chan_if.sink      wr,
  output pef_pkg::cfg_regs_t regs
);

  assign wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr.valid) begin
      case (wr.data.index)
        pef_pkg::REG_KIND: begin
          regs.kind <= wr.data.value[0];
        end
        pef_pkg::REG_LEVEL: begin
          regs.level <= wr.data.value[pef_pkg::LEVEL_W-1:0];
        end
        pef_pkg::REG_SPACING: begin
          regs.spacing <= wr.data.value[pef_pkg::SPACING_W-1:0];
        end
        default: begin
          // unmapped index: ignored
        end
      endcase
    end
  end

endmodule

@@ sv/pef_core.sv @@
module pef_core #(
  parameter int MAX_LEN     = pef_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_BITS = pef_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  pef_pkg::in_beat_t   beat,
  input  pef_pkg::cfg_regs_t  regs,
  output logic                has_res,
  output pef_pkg::res_beat_t  res
);

  // index holds 0..MAX_LEN
  localparam int IW = $clog2(MAX_LEN + 1);
  localparam int CW = (SAMPLE_BITS > pef_pkg::LEVEL_W) ? SAMPLE_BITS : pef_pkg::LEVEL_W;
  localparam int DW = (IW > pef_pkg::SPACING_W) ? IW : pef_pkg::SPACING_W;
  localparam int PW = (IW > pef_pkg::POS_W) ? IW : pef_pkg::POS_W;

  logic [SAMPLE_BITS-1:0]      previous_sample;
  logic [SAMPLE_BITS-1:0]      older_sample;
  logic [IW-1:0]               sample_index;
  logic [IW-1:0]               last_accepted;
  logic [pef_pkg::COUNT_W-1:0] accepted_count;

  logic [SAMPLE_BITS-1:0]      cur;
  logic [CW-1:0]               mid_w, old_w, cur_w, lvl_w;
  logic                        in_range, judge, hit, spaced, accept;
  logic [IW-1:0]               cand, span;
  logic [DW-1:0]               span_w, spacing_w;
  logic [PW-1:0]               cand_w;
  logic [pef_pkg::COUNT_W-1:0] count_next;

  always_comb begin
    cur       = SAMPLE_BITS'(beat.sample);
    mid_w     = CW'(previous_sample);
    old_w     = CW'(older_sample);
    cur_w     = CW'(cur);
    lvl_w     = CW'(regs.level);
    in_range  = sample_index < IW'(MAX_LEN);
    judge     = in_range && (sample_index >= IW'(2));
    if (regs.kind == pef_pkg::KIND_PEAK) begin
      hit = (mid_w > old_w) && (mid_w > cur_w) && (mid_w > lvl_w);
    end else begin
      hit = (mid_w < old_w) && (mid_w < cur_w) && (mid_w < lvl_w);
    end
    cand      = sample_index - IW'(1);
    span      = cand - last_accepted;
    span_w    = DW'(span);
    spacing_w = DW'(regs.spacing);
    spaced    = (accepted_count == '0) || (span_w >= spacing_w);
    accept    = judge && hit && spaced;
    cand_w    = PW'(cand);
    if (accept && (accepted_count != pef_pkg::COUNT_MAX)) begin
      count_next = accepted_count + pef_pkg::COUNT_W'(1);
    end else begin
      count_next = accepted_count;
    end
    has_res      = accept || beat.is_last;
    res.found    = accept;
    res.position = accept ? cand_w[pef_pkg::POS_W-1:0] : '0;
    res.total    = count_next;
    res.done_res = beat.is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      older_sample    <= '0;
      sample_index    <= '0;
      last_accepted   <= '0;
      accepted_count  <= '0;
    end else if (step) begin
      if (beat.is_last) begin
        previous_sample <= '0;
        older_sample    <= '0;
        sample_index    <= '0;
        last_accepted   <= '0;
        accepted_count  <= '0;
      end else begin
        if (in_range) begin
          older_sample    <= previous_sample;
          previous_sample <= cur;
          sample_index    <= sample_index + IW'(1);
        end
        if (accept) begin
          last_accepted  <= cand;
          accepted_count <= count_next;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    step && beat.is_last |=> (sample_index == '0) && (accepted_count == '0))
    else $error("profile state not cleared after last sample");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    sample_index <= IW'(MAX_LEN))
    else $error("sample index beyond profile limit");

  a_accept_records: assert property (@(posedge clk) disable iff (rst)
    step && accept && !beat.is_last |=>
      (accepted_count != '0) && (last_accepted == $past(cand)))
    else $error("accepted extremum not recorded");

  a_edge_never_judged: assert property (@(posedge clk) disable iff (rst)
    accept |-> (cand != '0) && (sample_index >= IW'(2)))
    else $error("first sample taken as extremum");
`endif

endmodule

@@ sv/profile_extremum_finder.sv @@
// Channel   Role  Beat payload                          Handshake
// cfg       sink  index[1:0], value[15:0]               valid/ready, ready tied high
// samples   sink  sample[15:0], is_last                 valid/ready
// extrema   src   found, position[11:0], total[11:0],   valid/ready
//                 done_res
//
// Throughput: one sample per cycle while extrema is not stalled; a sample beat
// reaches its result beat through the input register, then the window compare
// and state update feeding the result register.
// Reset (rst, sync, active high) clears the registers, the profile state and
// both pipeline valid flags.
// A stalled result register holds the core; an empty input register still
// takes one more beat, then samples.ready stays low until extrema is drained.
module profile_extremum_finder #(
  parameter int MAX_LEN     = pef_pkg::MAX_LEN_DEF,
  parameter int SAMPLE_BITS = pef_pkg::SAMPLE_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  pef_chan_if.sink   cfg,
  pef_chan_if.sink   samples,
  pef_chan_if.source extrema
);

  pef_pkg::cfg_regs_t regs;

  // input register
  logic               in_full;
  pef_pkg::in_beat_t  in_data;

  // result register
  logic               out_full;
  pef_pkg::res_beat_t out_data;

  logic               advance;
  logic               core_has_res;
  pef_pkg::res_beat_t core_res;

  pef_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .wr   (cfg),
    .regs (regs)
  );

  // core steps when an item sits in the input register and the result slot
  // is free or being drained this cycle
  assign advance       = in_full && (!out_full || extrema.ready);
  assign samples.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (samples.ready) begin
      in_full <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_data <= samples.data;
    end
  end

  pef_core #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .beat    (in_data),
    .regs    (regs),
    .has_res (core_has_res),
    .res     (core_res)
  );

  // result register: loaded only by items that produce a beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance && core_has_res) begin
      out_full <= 1'b1;
    end else if (extrema.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_has_res) begin
      out_data <= core_res;
    end
  end

  assign extrema.valid = out_full;
  assign extrema.data  = out_data;

endmodule

@@ bench/profile_extremum_finder_tb.sv @@
`timescale 1ns / 100ps

module profile_extremum_finder_tb;

  localparam int PROFILE_MAX  = pef_pkg::MAX_LEN_DEF;
  localparam int RANDOM_ITEMS = 1500;
  // leave room for beats that make no result
  localparam int SETTLE_CYCLES = 6;
  localparam int TIMEOUT_NS    = 2_000_000;

  // index outside the register map, the write must be dropped
  localparam logic [pef_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE} row_op_t;
  // how a directed sample row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} row_chk_t;
  // value shapes for random profiles
  typedef enum logic [1:0] {SHAPE_NOISE, SHAPE_NARROW, SHAPE_EDGE, SHAPE_RAIL} shape_t;

  typedef struct {
    row_op_t                       op;
    logic [pef_pkg::CFG_IDX_W-1:0] reg_idx;  // write rows only
    logic [15:0]                   value;    // register data or sample
    logic                          is_last;
    row_chk_t                      chk;
    pef_pkg::res_beat_t            exp;      // CHK_GIVEN only
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  pef_chan_if #(.T(pef_pkg::cfg_beat_t)) cfg ();
  pef_chan_if #(.T(pef_pkg::in_beat_t))  samples ();
  pef_chan_if #(.T(pef_pkg::res_beat_t)) extrema ();

  profile_extremum_finder #(
    .MAX_LEN     (PROFILE_MAX),
    .SAMPLE_BITS (pef_pkg::SAMPLE_BITS_DEF)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .samples (samples),
    .extrema (extrema)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor: register copy plus the sliding three-sample window state
  // ---------------------------------------------------------------------
  pef_pkg::cfg_regs_t regs_model;
  logic [15:0] prev_value, older_value;
  int unsigned next_index;       // saturates at PROFILE_MAX (stops advancing)
  int unsigned last_pos;
  int unsigned accepted_so_far;

  pef_pkg::res_beat_t pending_extrema [$];
  int        fail_count  = 0;
  int        sent_count  = 0;
  bit        sender_calm = 1'b0;
  bit        drain_calm  = 1'b0;

  function automatic void restart_profile();
    prev_value      = '0;
    older_value     = '0;
    next_index      = 0;
    last_pos        = 0;
    accepted_so_far = 0;
  endfunction

  // Judges the middle sample of the window when a new beat arrives.
  // Returns 1 when the beat yields a result beat.
  function automatic bit next_extremum(input pef_pkg::in_beat_t beat,
                                       output pef_pkg::res_beat_t res);
    bit          hit;
    bit          found;
    int unsigned cand;
    int unsigned pos;
    hit   = 1'b0;
    found = 1'b0;
    pos   = 0;
    // past the end of the window range nothing is judged or stored
    if (next_index < PROFILE_MAX) begin
      if (next_index >= 2) begin
        if (regs_model.kind == pef_pkg::KIND_PEAK) begin
          hit = prev_value > older_value && prev_value > beat.sample &&
                prev_value > regs_model.level;
        end else begin
          hit = prev_value < older_value && prev_value < beat.sample &&
                prev_value < regs_model.level;
        end
        if (hit) begin
          cand = next_index - 1;
          // first one always taken, later ones honor the spacing
          if (accepted_so_far == 0 || cand - last_pos >= regs_model.spacing) begin
            found    = 1'b1;
            pos      = cand;
            last_pos = cand;
            if (accepted_so_far < pef_pkg::COUNT_MAX) accepted_so_far++;
          end
        end
      end
      older_value = prev_value;
      prev_value  = beat.sample;
      next_index++;
    end
    res.found    = found;
    res.position = pos[pef_pkg::POS_W-1:0];
    res.total    = accepted_so_far[pef_pkg::COUNT_W-1:0];
    res.done_res = beat.is_last;
    if (beat.is_last) restart_profile();
    return found || beat.is_last;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table. Rows with a typed result are the obvious ones; the
  // rest go through the predictor.
  // ---------------------------------------------------------------------
  dir_row_t script [$] = '{
    // after reset: peaks, level 0, spacing 0; rails at both ends
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0000, 1'b0, CHK_NONE,  '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'hFFFF, 1'b0, CHK_NONE,  '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0000, 1'b0, CHK_GIVEN, '{1'b1, 12'd1, 12'd1, 1'b0}},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'hFFFF, 1'b1, CHK_GIVEN, '{1'b0, 12'd0, 12'd1, 1'b1}},
    // one-sample profile: first and last, never judged
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h1234, 1'b1, CHK_GIVEN, '{1'b0, 12'd0, 12'd0, 1'b1}},
    // plateau: equal neighbours are not strict extrema
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0005, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0007, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0007, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0005, 1'b1, CHK_GIVEN, '{1'b0, 12'd0, 12'd0, 1'b1}},
    // valleys below 0x8000, spacing 3; upper data bits must be masked off
    '{ROW_WRITE,  pef_pkg::REG_KIND,    16'hFFFF, 1'b0, CHK_NONE, '0},
    '{ROW_WRITE,  pef_pkg::REG_LEVEL,   16'h8000, 1'b0, CHK_NONE, '0},
    '{ROW_WRITE,  pef_pkg::REG_SPACING, 16'hF003, 1'b0, CHK_NONE, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0009, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0001, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0009, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0002, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0009, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0003, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0009, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0000, 1'b1, CHK_MODEL, '0},
    // extremum found on the closing beat
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0003, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0001, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0005, 1'b1, CHK_GIVEN, '{1'b1, 12'd1, 12'd1, 1'b1}},
    // unmapped index is dropped; peaks over a full-scale level never qualify
    '{ROW_WRITE,  REG_UNMAPPED,         16'hFFFF, 1'b0, CHK_NONE, '0},
    '{ROW_WRITE,  pef_pkg::REG_KIND,    16'h0000, 1'b0, CHK_NONE, '0},
    '{ROW_WRITE,  pef_pkg::REG_LEVEL,   16'hFFFF, 1'b0, CHK_NONE, '0},
    '{ROW_WRITE,  pef_pkg::REG_SPACING, 16'h0000, 1'b0, CHK_NONE, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0000, 1'b0, CHK_NONE,  '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'hFFFF, 1'b0, CHK_NONE,  '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0000, 1'b1, CHK_GIVEN, '{1'b0, 12'd0, 12'd0, 1'b1}},
    // max spacing: only the first peak of the profile survives
    '{ROW_WRITE,  pef_pkg::REG_LEVEL,   16'h0000, 1'b0, CHK_NONE, '0},
    '{ROW_WRITE,  pef_pkg::REG_SPACING, 16'hFFFF, 1'b0, CHK_NONE, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0000, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0005, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0000, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0005, 1'b0, CHK_MODEL, '0},
    '{ROW_SAMPLE, REG_UNMAPPED, 16'h0000, 1'b1, CHK_MODEL, '0}
  };

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Leaves samples.valid high so back-to-back beats never bounce it.
  task automatic send_sample(input logic [15:0] value, input logic last,
                             input row_chk_t chk, input pef_pkg::res_beat_t given);
    int                 gap;
    pef_pkg::in_beat_t  beat;
    pef_pkg::res_beat_t res;
    bit                 has_res;
    gap          = sender_calm ? 0 : $urandom_range(0, 5);
    beat.sample  = value;
    beat.is_last = last;
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.data  <= beat;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    has_res = next_extremum(beat, res);
    case (chk)
      CHK_MODEL: if (has_res) pending_extrema.push_back(res);
      CHK_GIVEN: pending_extrema.push_back(given);
      default: ;  // beat must produce nothing
    endcase
    sent_count++;
  endtask

  // Caller drops cfg.valid after the last write of a burst.
  task automatic write_reg(input logic [pef_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    pef_pkg::cfg_beat_t beat;
    beat.index = idx;
    beat.value = value;
    cfg.valid <= 1'b1;
    cfg.data  <= beat;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      pef_pkg::REG_KIND:    regs_model.kind    = value[0];
      pef_pkg::REG_LEVEL:   regs_model.level   = value;
      pef_pkg::REG_SPACING: regs_model.spacing = value[pef_pkg::SPACING_W-1:0];
      default: ;  // unmapped, ignored
    endcase
  endtask

  // Hold the sample stream until every expected beat is out and the pipe
  // has emptied of beats that make no result.
  task automatic settle();
    samples.valid <= 1'b0;
    while (pending_extrema.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random register set, extremes weighted in; upper data bits random.
  task automatic reconfigure();
    logic [15:0] value;
    if ($urandom_range(0, 1)) begin
      value    = 16'($urandom);
      value[0] = $urandom_range(0, 1) ? pef_pkg::KIND_VALLEY : pef_pkg::KIND_PEAK;
      write_reg(pef_pkg::REG_KIND, value);
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 4))
        0:       value = 16'h0000;
        1:       value = 16'hFFFF;
        default: value = 16'($urandom);
      endcase
      write_reg(pef_pkg::REG_LEVEL, value);
    end
    if ($urandom_range(0, 1)) begin
      value = 16'($urandom);
      case ($urandom_range(0, 5))
        0:       value[11:0] = 12'd0;
        1:       value[11:0] = 12'hFFF;
        2:       value[11:0] = 12'($urandom);
        default: value[11:0] = 12'($urandom_range(0, 6));
      endcase
      write_reg(pef_pkg::REG_SPACING, value);
    end
    if ($urandom_range(0, 5) == 0) write_reg(REG_UNMAPPED, 16'($urandom));
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [15:0] draw_sample(input shape_t shape, input logic [15:0] base);
    logic [15:0] v;
    case (shape)
      SHAPE_NOISE:  v = 16'($urandom);
      SHAPE_NARROW: v = base + 16'($urandom_range(0, 3));  // lots of ties
      SHAPE_EDGE:   v = regs_model.level + 16'($urandom_range(0, 4)) - 16'd2;
      default:      v = ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) ^
                        16'($urandom_range(0, 1));
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random backpressure, with calm stretches now and then
  // ---------------------------------------------------------------------
  initial begin
    int stall;
    extrema.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) drain_calm = !drain_calm;
      stall = drain_calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        extrema.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      extrema.ready <= 1'b1;
      @(posedge clk);
      while (!extrema.valid) @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [11:0] want,
                                      input logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Scoreboard: every accepted result beat against the oldest expectation
  always @(posedge clk) begin
    pef_pkg::res_beat_t want;
    if (!rst && extrema.valid && extrema.ready) begin
      if (pending_extrema.size() == 0) begin
        $error("result beat with nothing expected: %p", extrema.data);
        fail_count++;
      end else begin
        want = pending_extrema.pop_front();
        check_field("found",    12'(want.found),    12'(extrema.data.found));
        check_field("position", want.position,      extrema.data.position);
        check_field("total",    want.total,         extrema.data.total);
        check_field("done_res", 12'(want.done_res), 12'(extrema.data.done_res));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int unsigned start_count;
    int unsigned plen;
    int unsigned phase_left;
    int unsigned long_len;
    shape_t      shape;
    logic [15:0] base;
    bit          prev_write;

    rst           <= 1'b1;
    cfg.valid     <= 1'b0;
    cfg.data      <= '0;
    samples.valid <= 1'b0;
    samples.data  <= '0;
    regs_model = '0;
    restart_profile();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table; register writes only with the block drained
    prev_write = 1'b0;
    foreach (script[r]) begin
      if (script[r].op == ROW_WRITE) begin
        if (!prev_write) settle();
        write_reg(script[r].reg_idx, script[r].value);
        if (r == script.size() - 1 || script[r + 1].op != ROW_WRITE) cfg.valid <= 1'b0;
        prev_write = 1'b1;
      end else begin
        send_sample(script[r].value, script[r].is_last, script[r].chk, script[r].exp);
        prev_write = 1'b0;
      end
    end

    // random profiles; phases end at arbitrary beats, sometimes mid-profile,
    // and each one drains the block before new register values go in
    start_count = sent_count;
    phase_left  = 0;
    while (sent_count - start_count < RANDOM_ITEMS) begin
      plen        = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300)
                                                : $urandom_range(1, 40);
      shape       = shape_t'($urandom_range(0, 3));
      base        = $urandom_range(0, 1) ? regs_model.level - 16'd2 : 16'($urandom);
      sender_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < plen; k++) begin
        if (phase_left == 0) begin
          settle();
          reconfigure();
          phase_left = $urandom_range(20, 200);
        end
        send_sample(draw_sample(shape, base), k == plen - 1, CHK_MODEL, '0);
        phase_left--;
      end
    end

    // overlong profile: alternating low/high so peaks land up to the last
    // judged index, then the tail past the window limit is ignored
    settle();
    write_reg(pef_pkg::REG_KIND, {15'($urandom), pef_pkg::KIND_PEAK});
    write_reg(pef_pkg::REG_LEVEL, 16'h0000);
    write_reg(pef_pkg::REG_SPACING, 16'd2);
    cfg.valid <= 1'b0;
    sender_calm = 1'b0;
    long_len = $urandom_range(PROFILE_MAX + 4, PROFILE_MAX + 100);
    for (int k = 0; k < long_len; k++) begin
      send_sample(k[0] ? 16'($urandom_range(16'h8000, 16'hFFFF))
                       : 16'($urandom_range(0, 16'h3FFF)),
                  k == long_len - 1, CHK_MODEL, '0);
    end

    settle();
    if (fail_count == 0) begin
      $display("profile_extremum_finder_tb passed");
    end else begin
      $display("profile_extremum_finder_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("profile_extremum_finder_tb failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/pef_pkg.sv
sv/pef_chan_if.sv
sv/pef_cfg.sv
sv/pef_core.sv
sv/profile_extremum_finder.sv
bench/profile_extremum_finder_tb.sv
